// ===== hw/rtl/caret_notation_char_display_top_macros.svh =====
// Assertion macros for the caret notation display block.
// Used by modules that include this header; needs no package.
`ifndef CARET_NOTATION_CHAR_DISPLAY_TOP_MACROS_SVH
`define CARET_NOTATION_CHAR_DISPLAY_TOP_MACROS_SVH

`ifndef SYNTH
`define CND_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CND_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CND_ASSERT_NOW(label, clk, rst, ante, cons)
`define CND_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/cnd_pkg.sv =====
// Shared types and character constants for the caret notation display block.
// No dependencies.
`default_nettype none

package cnd_pkg;

   localparam int CHAR_W  = 7;
   localparam int RUN_MAX = 6;
   localparam int CNT_W   = 3;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [6:0] CH_CARET = 7'h5E;
   localparam logic [6:0] CH_M     = 7'h4D;
   localparam logic [6:0] CH_DASH  = 7'h2D;
   localparam logic [6:0] CH_AT    = 7'h40;
   localparam logic [6:0] CH_FIRST = 7'h20;
   localparam logic [6:0] CH_LAST  = 7'h7E;

   localparam logic ADDR_MODE = 1'b0;

   typedef logic [CHAR_W-1:0] char_type;

   typedef struct packed {
      logic [RUN_MAX-1:0][CHAR_W-1:0] chars;
      logic [CNT_W-1:0]               cnt;
      logic                           cr_next;
   } run_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cnd_ifs.sv =====
// Valid/ready channel interfaces for received bytes and display characters.
// Depends on cnd_pkg.
`default_nettype none

interface cnd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface cnd_rsp_if
   import cnd_pkg::*;
;
   logic     valid;
   logic     ready;
   char_type out_char;
   logic     run_last;

   modport source (output valid, output out_char, output run_last, input ready);
   modport sink (input valid, input out_char, input run_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cnd_expand.sv =====
// Expands one received byte into its run of display characters.
// Depends on cnd_pkg.
`default_nettype none

module cnd_expand
   import cnd_pkg::*;
(
   input  wire logic [7:0] rx_byte,
   input  wire logic       seven_bit_mode,
   input  wire logic       cr_pending,
   output run_type         run
);

   logic [7:0]     b;
   char_type       lo;
   char_type       ctl;
   logic           printable;
   logic [3:0][CHAR_W-1:0] body;
   logic [CNT_W-1:0] body_cnt;

   always_comb begin
      b         = seven_bit_mode ? {1'b0, rx_byte[6:0]} : rx_byte;
      lo        = b[6:0];
      ctl       = lo ^ CH_AT;
      printable = (lo >= CH_FIRST && lo <= CH_LAST) || b == CH_BS || b == CH_TAB;

      body = '0;
      if (b[7]) begin
         body[0]  = CH_M;
         body[1]  = CH_DASH;
         body[2]  = printable ? lo : CH_CARET;
         body[3]  = printable ? '0 : ctl;
         body_cnt = printable ? CNT_W'(3) : CNT_W'(4);
      end else begin
         body[0]  = printable ? lo : CH_CARET;
         body[1]  = printable ? '0 : ctl;
         body_cnt = printable ? CNT_W'(1) : CNT_W'(2);
      end

      run = '0;
      if (cr_pending && b == CH_LF) begin
         run.chars[0] = CH_CR[CHAR_W-1:0];
         run.chars[1] = CH_LF[CHAR_W-1:0];
         run.cnt      = CNT_W'(2);
         run.cr_next  = 1'b0;
      end else if (cr_pending) begin
         run.chars[0] = CH_CARET;
         run.chars[1] = CH_M;
         run.chars[2] = body[0];
         run.chars[3] = body[1];
         run.chars[4] = body[2];
         run.chars[5] = body[3];
         run.cnt      = (b == CH_CR) ? CNT_W'(2) : body_cnt + CNT_W'(2);
         run.cr_next  = (b == CH_CR);
      end else begin
         run.chars[0] = body[0];
         run.chars[1] = body[1];
         run.chars[2] = body[2];
         run.chars[3] = body[3];
         run.cnt      = (b == CH_CR) ? '0 : body_cnt;
         run.cr_next  = (b == CH_CR);
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/caret_notation_char_display_top.sv =====
// Top level of the caret notation display block: register port, run buffer
// and output register. Depends on cnd_pkg, cnd_ifs, cnd_expand and the macro header.
//
//   channel  | dir | beat
//   req_ch   | in  | rx_byte, one received byte
//   rsp_ch   | out | out_char + run_last, one display character
//   csr APB  | in  | seven_bit_mode at byte address 0
//
// A byte is expanded in the cycle it is accepted; its 0 to 6 characters leave
// one per cycle from the output register while rsp_ch.ready is high; a low ready
// holds the output register and the run buffer.
// A byte with an empty run (a held carriage return) loads nothing into the run buffer.
// The next byte is taken in the cycle the last character of the run moves out.
// Synchronous reset clears the mode, the held carriage return and all valids.
`default_nettype none
`include "caret_notation_char_display_top_macros.svh"

module caret_notation_char_display_top
   import cnd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   cnd_req_if.sink          req_ch,
   cnd_rsp_if.source        rsp_ch,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

   logic             seven_ff, seven_in;
   logic             cr_pending_ff, cr_pending_in;
   logic             run_valid_ff, run_valid_in;
   logic [CNT_W-1:0] run_left_ff, run_left_in;
   logic [RUN_MAX-1:0][CHAR_W-1:0] run_chars_ff, run_chars_in;
   logic             rsp_valid_ff, rsp_valid_in;
   char_type         rsp_char_ff, rsp_char_in;
   logic             rsp_last_ff, rsp_last_in;

   run_type          exp_run;
   logic             out_free;
   logic             move;
   logic             run_done;
   logic             req_ready;
   logic             accept;

   cnd_expand u_expand (
      .rx_byte        (req_ch.rx_byte),
      .seven_bit_mode (seven_ff),
      .cr_pending     (cr_pending_ff),
      .run            (exp_run)
   );

   assign pready = 1'b1;
   assign prdata = (paddr[2] == ADDR_MODE) ? {31'b0, seven_ff} : '0;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign move      = run_valid_ff && out_free;
   assign run_done  = move && run_left_ff == CNT_W'(1);
   assign req_ready = !run_valid_ff || run_done;
   assign accept    = req_ch.valid && req_ready;

   assign req_ch.ready    = req_ready;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_char = rsp_char_ff;
   assign rsp_ch.run_last = rsp_last_ff;

   always_comb begin
      seven_in = seven_ff;
      if (psel && penable && pwrite && paddr[2] == ADDR_MODE) begin
         seven_in = pwdata[0];
      end

      cr_pending_in = accept ? exp_run.cr_next : cr_pending_ff;

      run_valid_in = run_valid_ff;
      run_left_in  = run_left_ff;
      run_chars_in = run_chars_ff;
      if (accept && exp_run.cnt != '0) begin
         run_valid_in = 1'b1;
         run_left_in  = exp_run.cnt;
         run_chars_in = exp_run.chars;
      end else if (move) begin
         run_valid_in = !run_done;
         run_left_in  = run_left_ff - CNT_W'(1);
         run_chars_in = run_chars_ff >> CHAR_W;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = run_valid_ff;
         rsp_char_in  = run_chars_ff[0];
         rsp_last_in  = run_left_ff == CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seven_ff      <= 1'b0;
         cr_pending_ff <= 1'b0;
         run_valid_ff  <= 1'b0;
         run_left_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         seven_ff      <= seven_in;
         cr_pending_ff <= cr_pending_in;
         run_valid_ff  <= run_valid_in;
         run_left_ff   <= run_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      run_chars_ff <= run_chars_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
   end

   `CND_ASSERT_NOW(a_run_left_range, clock, reset, run_valid_ff,
      run_left_ff != '0 && run_left_ff <= CNT_W'(RUN_MAX))
   `CND_ASSERT_NEXT(a_run_continues, clock, reset, move && run_left_ff != CNT_W'(1),
      run_valid_ff)
   `CND_ASSERT_NEXT(a_empty_run_holds_cr, clock, reset, accept && exp_run.cnt == '0,
      cr_pending_ff && !run_valid_ff)
   `CND_ASSERT_NOW(a_accept_frees_run, clock, reset, accept && run_valid_ff, run_done)

endmodule

`default_nettype wire
